### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define ASSERT_ON(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hdl/dfst_pkg.sv
// ---------------------------------------------------------------------------
// dfst_pkg
// Types, constants, specifier table and microcode for the date-format
// specifier translator.
// ---------------------------------------------------------------------------
package dfst_pkg;

  localparam logic [7:0] PCT = 8'h25;
  localparam int NUM_SPECS = 22;
  localparam int TEXT_BYTES = 11;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRAIL = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  // microprogram addresses
  localparam logic [2:0] UA_FETCH  = 3'd0;
  localparam logic [2:0] UA_DROP   = 3'd1;
  localparam logic [2:0] UA_PEND   = 3'd2;
  localparam logic [2:0] UA_PASS   = 3'd3;
  localparam logic [2:0] UA_TRAIL  = 3'd4;
  localparam logic [2:0] UA_UNK    = 3'd5;
  localparam logic [2:0] UA_EXPAND = 3'd6;

  // output byte source
  localparam logic [1:0] OS_CHAR = 2'd0;
  localparam logic [1:0] OS_TEXT = 2'd1;
  localparam logic [1:0] OS_ZERO = 2'd2;

  // flag operations
  localparam logic [1:0] FOP_KEEP  = 2'd0;
  localparam logic [1:0] FOP_SET   = 2'd1;
  localparam logic [1:0] FOP_CLR   = 2'd2;
  localparam logic [1:0] FOP_NLAST = 2'd3;

  // jump conditions
  localparam logic [1:0] JC_DISPATCH  = 2'd0;
  localparam logic [1:0] JC_GOTO      = 2'd1;
  localparam logic [1:0] JC_UNTIL_FIN = 2'd2;

  typedef struct packed {
    logic       wait_in;
    logic       emit;
    logic [1:0] osel;
    logic [1:0] status;
    logic       rl_fin;   // run_last follows the end of the expansion run
    logic       se_one;   // string_end forced high
    logic [1:0] pend_op;
    logic [1:0] drop_op;
    logic       ptr_inc;
    logic [1:0] jc;
    logic [2:0] target;
  } ctl_word_t;

  typedef struct packed {
    ctl_word_t cw;
    logic      fire;
  } seq_ctl_t;

  typedef struct packed {
    logic [2:0] dispatch;
    logic       fin;
    logic       out_free;
    logic       in_valid;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0]              key;
    logic [3:0]              len;
    logic [8*TEXT_BYTES-1:0] text;  // right aligned, last byte in [7:0]
  } spec_t;

  function automatic spec_t spec_entry(input logic [4:0] idx);
    spec_t e;
    e = '{key: 8'h00, len: 4'd2, text: 88'h0};
    unique case (idx)
      5'd0:  e = '{key: "Y", len: 4'd2,  text: 88'("%Y")};
      5'd1:  e = '{key: "y", len: 4'd2,  text: 88'("%y")};
      5'd2:  e = '{key: "m", len: 4'd2,  text: 88'("%m")};
      5'd3:  e = '{key: "c", len: 4'd3,  text: 88'("%-m")};
      5'd4:  e = '{key: "d", len: 4'd2,  text: 88'("%d")};
      5'd5:  e = '{key: "e", len: 4'd3,  text: 88'("%-d")};
      5'd6:  e = '{key: "H", len: 4'd2,  text: 88'("%H")};
      5'd7:  e = '{key: "k", len: 4'd3,  text: 88'("%-H")};
      5'd8:  e = '{key: "h", len: 4'd2,  text: 88'("%I")};
      5'd9:  e = '{key: "I", len: 4'd2,  text: 88'("%I")};
      5'd10: e = '{key: "l", len: 4'd3,  text: 88'("%-I")};
      5'd11: e = '{key: "i", len: 4'd2,  text: 88'("%M")};
      5'd12: e = '{key: "S", len: 4'd2,  text: 88'("%S")};
      5'd13: e = '{key: "s", len: 4'd2,  text: 88'("%S")};
      5'd14: e = '{key: "f", len: 4'd2,  text: 88'("%f")};
      5'd15: e = '{key: "p", len: 4'd2,  text: 88'("%p")};
      5'd16: e = '{key: "T", len: 4'd8,  text: 88'("%H:%M:%S")};
      5'd17: e = '{key: "r", len: 4'd11, text: 88'("%I:%M:%S %p")};
      5'd18: e = '{key: "b", len: 4'd2,  text: 88'("%b")};
      5'd19: e = '{key: "M", len: 4'd2,  text: 88'("%B")};
      5'd20: e = '{key: "a", len: 4'd2,  text: 88'("%a")};
      5'd21: e = '{key: "W", len: 4'd2,  text: 88'("%A")};
      default: e = '{key: 8'h00, len: 4'd2, text: 88'h0};
    endcase
    return e;
  endfunction

  function automatic ctl_word_t ucode_rom(input logic [2:0] ua);
    ctl_word_t w;
    w = '{wait_in: 1'b1, emit: 1'b0, osel: OS_ZERO, status: ST_OK, rl_fin: 1'b0,
          se_one: 1'b0, pend_op: FOP_KEEP, drop_op: FOP_KEEP, ptr_inc: 1'b0,
          jc: JC_DISPATCH, target: UA_FETCH};
    unique case (ua)
      UA_FETCH: ;
      UA_DROP: begin
        w.wait_in = 1'b0; w.drop_op = FOP_NLAST; w.jc = JC_GOTO;
      end
      UA_PEND: begin
        w.wait_in = 1'b0; w.pend_op = FOP_SET; w.jc = JC_GOTO;
      end
      UA_PASS: begin
        w.wait_in = 1'b0; w.emit = 1'b1; w.osel = OS_CHAR;
        w.pend_op = FOP_CLR; w.jc = JC_GOTO;
      end
      UA_TRAIL: begin
        w.wait_in = 1'b0; w.emit = 1'b1; w.status = ST_TRAIL; w.se_one = 1'b1;
        w.drop_op = FOP_CLR; w.jc = JC_GOTO;
      end
      UA_UNK: begin
        w.wait_in = 1'b0; w.emit = 1'b1; w.status = ST_UNSUP; w.se_one = 1'b1;
        w.pend_op = FOP_CLR; w.drop_op = FOP_NLAST; w.jc = JC_GOTO;
      end
      UA_EXPAND: begin
        w.wait_in = 1'b0; w.emit = 1'b1; w.osel = OS_TEXT; w.rl_fin = 1'b1;
        w.pend_op = FOP_CLR; w.ptr_inc = 1'b1; w.jc = JC_UNTIL_FIN;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

### hdl/dfst_stream_if.sv
// ---------------------------------------------------------------------------
// dfst stream interfaces
// Valid/ready channels for format bytes in and translated bytes out.
// ---------------------------------------------------------------------------
interface dfst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface dfst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic [1:0] status;
  logic       string_end;

  modport source (output valid, output out_char, output run_last, output status,
                  output string_end, input ready);
  modport sink   (input valid, input out_char, input run_last, input status,
                  input string_end, output ready);
endinterface

### hdl/dfst_sequencer.sv
// ---------------------------------------------------------------------------
// dfst_sequencer
// Micro-program counter and control-store lookup with conditional jumps.
// ---------------------------------------------------------------------------
module dfst_sequencer import dfst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output seq_ctl_t ctl
);

  logic [2:0] upc;
  logic [2:0] upc_next;
  ctl_word_t  cw;
  logic       fire;

  assign cw = ucode_rom(upc);

  // a step completes when its input or output transfer can happen
  always_comb begin
    priority if (cw.wait_in) begin
      fire = stat.in_valid;
    end else if (cw.emit) begin
      fire = stat.out_free;
    end else begin
      fire = 1'b1;
    end
  end

  always_comb begin
    upc_next = upc;
    if (fire) begin
      unique case (cw.jc)
        JC_DISPATCH:  upc_next = stat.dispatch;
        JC_GOTO:      upc_next = cw.target;
        JC_UNTIL_FIN: upc_next = stat.fin ? cw.target : upc;
        default:      upc_next = UA_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctl = '{cw: cw, fire: fire};

endmodule

### hdl/dfst_datapath.sv
// ---------------------------------------------------------------------------
// dfst_datapath
// Byte latch, specifier lookup, expansion pointer, mode flags and the
// output register.
// ---------------------------------------------------------------------------
module dfst_datapath import dfst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  seq_ctl_t ctl,
  output dp_stat_t stat,
  dfst_in_if.sink    in_stream,
  dfst_out_if.source out_stream
);

  logic [7:0] ch_r;
  logic       last_r;
  logic [4:0] idx_r;
  logic [3:0] ptr;
  logic       percent_pending;
  logic       drop_until_end;
  logic       out_valid;
  logic [7:0] out_char_r;
  logic       run_last_r;
  logic [1:0] status_r;
  logic       string_end_r;

  logic       hit;
  logic [4:0] hit_idx;
  spec_t      ent;
  logic [3:0] pos;
  logic       fin;
  logic [7:0] text_byte;
  logic [7:0] byte_sel;
  logic       out_free;
  logic [2:0] dispatch;
  logic       fetch;

  // parallel match of the incoming byte against all specifier keys
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_SPECS; i++) begin
      if (spec_entry(5'(i)).key == in_stream.in_char) begin
        hit     = 1'b1;
        hit_idx = 5'(i);
      end
    end
  end

  always_comb begin
    priority if (drop_until_end) begin
      dispatch = UA_DROP;
    end else if (percent_pending) begin
      if (in_stream.in_char == PCT) begin
        dispatch = UA_PASS;
      end else if (hit) begin
        dispatch = UA_EXPAND;
      end else begin
        dispatch = UA_UNK;
      end
    end else if (in_stream.in_char == PCT) begin
      dispatch = in_stream.in_last ? UA_TRAIL : UA_PEND;
    end else begin
      dispatch = UA_PASS;
    end
  end

  assign ent       = spec_entry(idx_r);
  assign fin       = (ptr == ent.len - 4'd1);
  assign pos       = ent.len - 4'd1 - ptr;
  assign text_byte = ent.text[{pos, 3'b000} +: 8];
  assign out_free  = !out_valid || out_stream.ready;
  assign fetch     = ctl.fire && ctl.cw.wait_in;

  always_comb begin
    unique case (ctl.cw.osel)
      OS_CHAR: byte_sel = ch_r;
      OS_TEXT: byte_sel = text_byte;
      default: byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      ch_r   <= in_stream.in_char;
      last_r <= in_stream.in_last;
      idx_r  <= hit_idx;
      ptr    <= '0;
    end else if (ctl.fire && ctl.cw.ptr_inc && !fin) begin
      ptr <= ptr + 4'd1;
    end
    if (ctl.fire && ctl.cw.emit) begin
      out_char_r   <= byte_sel;
      status_r     <= ctl.cw.status;
      run_last_r   <= ctl.cw.rl_fin ? fin : 1'b1;
      string_end_r <= ctl.cw.se_one | (last_r & (ctl.cw.rl_fin ? fin : 1'b1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
      drop_until_end  <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (ctl.fire) begin
        unique case (ctl.cw.pend_op)
          FOP_SET:  percent_pending <= 1'b1;
          FOP_CLR:  percent_pending <= 1'b0;
          default:  percent_pending <= percent_pending;
        endcase
        unique case (ctl.cw.drop_op)
          FOP_CLR:   drop_until_end <= 1'b0;
          FOP_NLAST: drop_until_end <= !last_r;
          default:   drop_until_end <= drop_until_end;
        endcase
      end
      if (ctl.fire && ctl.cw.emit) begin
        out_valid <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold off input transfers while reset is asserted
  assign in_stream.ready       = ctl.cw.wait_in && !rst;
  assign out_stream.valid      = out_valid;
  assign out_stream.out_char   = out_char_r;
  assign out_stream.run_last   = run_last_r;
  assign out_stream.status     = status_r;
  assign out_stream.string_end = string_end_r;

  assign stat = '{dispatch: dispatch, fin: fin, out_free: out_free,
                  in_valid: in_stream.valid};

endmodule

### hdl/date_format_specifier_translator.sv
// ---------------------------------------------------------------------------
// date_format_specifier_translator
// Streams a date-format string byte by byte and writes translated bytes.
// ---------------------------------------------------------------------------
// Usage: in_stream carries one format byte per transfer (in_char) with
// in_last on the final byte of a string. out_stream carries translated
// bytes with run_last on the last byte caused by one input, status (ok,
// trailing percent, unsupported specifier) and string_end.
// Timing: an input transfer is taken in the fetch step; each output byte
// takes one further step, and an input that produces none of its 0 to 11
// bytes still takes one step after the fetch. The micro-program counter
// walks one control word per cycle unless a step waits for its transfer,
// and handles one input at a time; expansions hold in_stream.ready low
// until their last byte is loaded into the output register.
// Reset (rst, synchronous) returns the sequencer to fetch, clears the
// pending-percent and drop flags and empties the output register.
// A stalled receiver holds the output register; the sequencer waits in
// its emit step, and a fetch still proceeds while the last byte waits.
// Error results carry out_char zero; bytes already sent for that string
// stay sent and the rest of the string is dropped up to in_last.
// ---------------------------------------------------------------------------
module date_format_specifier_translator import dfst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dfst_in_if.sink    in_stream,
  dfst_out_if.source out_stream
);

  seq_ctl_t ctl;
  dp_stat_t stat;

  dfst_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  dfst_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

endmodule

### hdl/dfst_checker.sv
// ---------------------------------------------------------------------------
// dfst_checker
// Port-level checks of the translator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfst_checker import dfst_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_last,
  input logic [1:0] status,
  input logic       string_end
);

  // hold a stalled result
  `ASSERT_ON(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_char))

  // error results are zero bytes that close the run and the string
  `ASSERT_ON(a_err_shape, clk, rst, out_valid && status != ST_OK |-> out_char == 8'h00 && run_last && string_end)

  // an ok string end only on the last byte of a run
  `ASSERT_ON(a_end_on_run_last, clk, rst, out_valid && string_end |-> run_last)

  // output empties on reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind date_format_specifier_translator dfst_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_char   (out_stream.out_char),
  .run_last   (out_stream.run_last),
  .status     (out_stream.status),
  .string_end (out_stream.string_end)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives date-format strings into the specifier translator byte by byte and
// checks every translated byte against a predictor that tracks the pending
// percent and the drop-to-end flag. Directed strings come first, then
// random strings in three phases of source and sink idling.
// ---------------------------------------------------------------------------
module testbench;
  import dfst_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;   // hold this byte until all results are in
  } fmt_byte_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic [1:0] status;
    logic       string_end;
  } xlat_byte_t;

  localparam string SPEC_KEYS = "YymcdeHkhIliSsfpTrbMaW";
  localparam int    DRAIN_LIMIT = 5000;
  localparam int    TAIL_CYCLES = 20;

  logic clk;
  logic rst;

  dfst_in_if  in_stream();
  dfst_out_if out_stream();

  date_format_specifier_translator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  fmt_byte_t  pending_fmt[$];
  xlat_byte_t expected_bytes[$];

  bit         pct_pending;
  bit         drop_active;
  bit         in_accepted;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         error_count;
  int         inputs_taken;
  int         results_checked;
  int         error_results;
  int         long_runs;
  xlat_byte_t want;
  fmt_byte_t  nxt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (error_count < 50) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
    error_count++;
  endtask

  function automatic string spec_text(input logic [7:0] key);
    case (key)
      "Y": return "%Y";
      "y": return "%y";
      "m": return "%m";
      "c": return "%-m";
      "d": return "%d";
      "e": return "%-d";
      "H": return "%H";
      "k": return "%-H";
      "h": return "%I";
      "I": return "%I";
      "l": return "%-I";
      "i": return "%M";
      "S": return "%S";
      "s": return "%S";
      "f": return "%f";
      "p": return "%p";
      "T": return "%H:%M:%S";
      "r": return "%I:%M:%S %p";
      "b": return "%b";
      "M": return "%B";
      "a": return "%a";
      "W": return "%A";
      default: return "";
    endcase
  endfunction

  task automatic queue_error(input logic [1:0] code, input logic last_byte);
    expected_bytes.push_back(xlat_byte_t'{out_char: 8'h00, run_last: 1'b1,
                                          status: code, string_end: 1'b1});
    drop_active = !last_byte;
  endtask

  task automatic predict_translation(input logic [7:0] ch, input logic last_byte);
    string txt;
    int    n;
    if (drop_active) begin
      if (last_byte) drop_active = 1'b0;
      return;
    end
    if (pct_pending) begin
      pct_pending = 1'b0;
      if (ch == PCT) begin
        expected_bytes.push_back(xlat_byte_t'{out_char: PCT, run_last: 1'b1,
                                              status: ST_OK, string_end: last_byte});
        return;
      end
      txt = spec_text(ch);
      n = txt.len();
      if (n == 0) begin
        queue_error(ST_UNSUP, last_byte);
        return;
      end
      if (n >= 8) long_runs++;
      for (int k = 0; k < n; k++) begin
        expected_bytes.push_back(xlat_byte_t'{out_char: 8'(txt[k]),
                                              run_last: (k == n - 1),
                                              status: ST_OK,
                                              string_end: (k == n - 1) && last_byte});
      end
      return;
    end
    if (ch == PCT) begin
      if (last_byte) queue_error(ST_TRAIL, 1'b1);
      else pct_pending = 1'b1;
      return;
    end
    expected_bytes.push_back(xlat_byte_t'{out_char: ch, run_last: 1'b1,
                                          status: ST_OK, string_end: last_byte});
  endtask

  task automatic push_fmt(input logic [7:0] ch, input logic last_byte,
                          input bit drain = 1'b0);
    pending_fmt.push_back(fmt_byte_t'{ch: ch, last: last_byte, drain_first: drain});
  endtask

  task automatic push_literal(input string s);
    for (int k = 0; k < s.len(); k++) begin
      push_fmt(8'(s[k]), k == s.len() - 1);
    end
  endtask

  // Build one random string: mostly well-formed, some ending in an error,
  // some plain noise. Junk bytes added after an unknown specifier are not counted.
  task automatic add_random_string(input bit drain, inout int counted);
    logic [7:0] body[$];
    logic [7:0] c;
    int         segs;
    int         mode;
    int         junk;
    int         kind;
    segs = $urandom_range(1, 5);
    mode = $urandom_range(99);
    junk = 0;
    if (mode < 12) begin
      repeat ($urandom_range(1, 6)) begin
        c = ($urandom_range(3) == 0) ? PCT : 8'($urandom_range(255));
        body.push_back(c);
      end
    end else begin
      repeat (segs) begin
        kind = $urandom_range(9);
        if (kind < 4) begin
          do c = 8'($urandom_range(255)); while (c == PCT);
          body.push_back(c);
        end else if (kind == 4) begin
          body.push_back(PCT);
          body.push_back(PCT);
        end else begin
          body.push_back(PCT);
          body.push_back(8'(SPEC_KEYS[$urandom_range(21)]));
        end
      end
      if (mode >= 78 && mode < 88) begin
        body.push_back(PCT);
      end else if (mode >= 88) begin
        body.push_back(PCT);
        do c = 8'($urandom_range(255)); while (c == PCT || spec_text(c).len() != 0);
        body.push_back(c);
        junk = $urandom_range(0, 4);
        repeat (junk) body.push_back(8'($urandom_range(255)));
      end
    end
    for (int k = 0; k < body.size(); k++) begin
      push_fmt(body[k], k == body.size() - 1, drain && k == 0);
    end
    counted += body.size() - junk;
  endtask

  task automatic wait_idle();
    int guard;
    while (pending_fmt.size() != 0 || in_stream.valid) @(posedge clk);
    guard = 0;
    while (expected_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic run_random_phase(input int src_pct, input int snk_pct, input int items);
    int counted;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    counted = 0;
    add_random_string(1'b1, counted);
    while (counted < items) begin
      add_random_string($urandom_range(99) < 3, counted);
    end
    wait_idle();
  endtask

  // Source side: hold a byte until its transfer, then advance.
  always @(negedge clk) begin
    if (rst) begin
      in_stream.valid <= 1'b0;
    end else if (!in_stream.valid || in_accepted) begin
      if (pending_fmt.size() != 0 &&
          !(pending_fmt[0].drain_first && expected_bytes.size() != 0) &&
          $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_fmt.pop_front();
        in_stream.valid   <= 1'b1;
        in_stream.in_char <= nxt.ch;
        in_stream.in_last <= nxt.last;
      end else begin
        in_stream.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stream.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // Check outputs before predicting: a new input cannot produce a result on
  // the edge of its own transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_accepted = 1'b0;
    end else begin
      if (out_stream.valid && out_stream.ready) begin
        results_checked++;
        if (out_stream.status != ST_OK) error_results++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result char=%02h status=%0d",
                                    out_stream.out_char, out_stream.status));
        end else begin
          want = expected_bytes.pop_front();
          if (out_stream.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %02h, want %02h",
                                      out_stream.out_char, want.out_char));
          if (out_stream.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b",
                                      out_stream.run_last, want.run_last));
          if (out_stream.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_stream.status, want.status));
          if (out_stream.string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, want %b",
                                      out_stream.string_end, want.string_end));
        end
      end
      in_accepted = in_stream.valid && in_stream.ready;
      if (in_accepted) begin
        inputs_taken++;
        predict_translation(in_stream.in_char, in_stream.in_last);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_stream.valid   = 1'b0;
    in_stream.in_char = 8'h00;
    in_stream.in_last = 1'b0;
    out_stream.ready  = 1'b0;
    pct_pending  = 1'b0;
    drop_active  = 1'b0;
    in_accepted  = 1'b0;
    src_idle_pct = 23;
    snk_idle_pct = 71;
    error_count  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, doubled percent, longest expansions,
    // trailing percent, unknown specifier mid-string and on the last byte,
    // a percent while dropping.
    push_fmt(8'h00, 1'b0);
    push_fmt(8'hFF, 1'b0);
    push_fmt("A", 1'b1);
    push_literal("%%");
    push_literal("%r");
    push_literal("%T");
    push_literal("x%");
    push_literal("%zab");
    push_literal("%Q");
    push_literal("%");
    push_fmt(PCT, 1'b0);
    push_fmt(8'hFF, 1'b0);
    push_fmt(PCT, 1'b1);
    push_literal("%k");

    run_random_phase(23, 71, 55);
    run_random_phase(71, 23, 55);
    run_random_phase(0, 0, 55);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_bytes.size()));

    $display("Run covered %0d input bytes and %0d checked results", inputs_taken,
             results_checked);
    $display("  including %0d error results and %0d long expansions", error_results,
             long_runs);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
